### hdl/efr_pkg.sv
package efr_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7e;
  localparam logic [7:0] ESC_BYTE    = 8'h7d;
  localparam logic [7:0] XON_BYTE    = 8'h11;
  localparam logic [7:0] XOFF_BYTE   = 8'h13;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] SUM_GOOD    = 8'hff;
  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CKSUM   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TYPE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_GOOD  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_DELIM    = 3'd1,
    ERR_ESCAPE   = 3'd2,
    ERR_ZERO_LEN = 3'd3,
    ERR_TOO_LONG = 3'd4,
    ERR_CHECKSUM = 3'd5
  } err_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    err_t        err;
  } result_t;

endpackage

### hdl/efr_decode.sv
module efr_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  output efr_pkg::result_t res
);

  efr_pkg::phase_t phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] max_len_r;

  logic        in_frame;
  logic [7:0]  ub;
  logic [15:0] len_m1;
  logic [15:0] cnt_p1;
  logic [7:0]  sum_add;

  assign in_frame = (phase_r != efr_pkg::PH_HUNT) && (phase_r <= efr_pkg::PH_CKSUM);
  assign ub       = rx_byte ^ efr_pkg::ESC_XOR;
  assign len_m1   = len_r - 16'd1;
  assign cnt_p1   = cnt_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    res       = '0;
    res.kind  = efr_pkg::KIND_TYPE;
    res.err   = efr_pkg::ERR_NONE;
    sum_add   = rx_byte;
    if (fire) begin
      if (!in_frame) begin
        if (rx_byte == efr_pkg::FLAG_BYTE) begin
          phase_nxt = efr_pkg::PH_LEN_HI;
          esc_nxt   = 1'b0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end else begin
          phase_nxt = efr_pkg::PH_HUNT;
        end
      end else if (esc_r && !(ub == efr_pkg::FLAG_BYTE || ub == efr_pkg::ESC_BYTE ||
                              ub == efr_pkg::XON_BYTE || ub == efr_pkg::XOFF_BYTE)) begin
        res.valid = 1'b1;
        res.kind  = efr_pkg::KIND_ERROR;
        res.index = cnt_r;
        res.err   = efr_pkg::ERR_ESCAPE;
        phase_nxt = efr_pkg::PH_HUNT;
        esc_nxt   = 1'b0;
      end else if (!esc_r && rx_byte == efr_pkg::FLAG_BYTE) begin
        // start byte inside a frame aborts it and is consumed
        res.valid = 1'b1;
        res.kind  = efr_pkg::KIND_ERROR;
        res.index = cnt_r;
        res.err   = efr_pkg::ERR_DELIM;
        phase_nxt = efr_pkg::PH_HUNT;
        esc_nxt   = 1'b0;
      end else if (!esc_r && rx_byte == efr_pkg::ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        sum_add = esc_r ? ub : rx_byte;
        unique case (phase_r)
          efr_pkg::PH_LEN_HI: begin
            len_nxt   = {sum_add, 8'h00};
            phase_nxt = efr_pkg::PH_LEN_LO;
          end
          efr_pkg::PH_LEN_LO: begin
            len_nxt = {len_r[15:8], sum_add};
            if ({len_r[15:8], sum_add} == 16'd0) begin
              res.valid = 1'b1;
              res.kind  = efr_pkg::KIND_ERROR;
              res.index = cnt_r;
              res.err   = efr_pkg::ERR_ZERO_LEN;
              phase_nxt = efr_pkg::PH_HUNT;
            end else begin
              phase_nxt = efr_pkg::PH_TYPE;
            end
          end
          efr_pkg::PH_TYPE: begin
            len_nxt = len_m1;
            if (len_m1 > max_len_r) begin
              res.valid = 1'b1;
              res.kind  = efr_pkg::KIND_ERROR;
              res.index = cnt_r;
              res.err   = efr_pkg::ERR_TOO_LONG;
              phase_nxt = efr_pkg::PH_HUNT;
            end else begin
              res.valid = 1'b1;
              res.kind  = efr_pkg::KIND_TYPE;
              res.data  = sum_add;
              sum_nxt   = sum_add;
              cnt_nxt   = '0;
              phase_nxt = (len_m1 == 16'd0) ? efr_pkg::PH_CKSUM : efr_pkg::PH_PAYLOAD;
            end
          end
          efr_pkg::PH_PAYLOAD: begin
            res.valid = 1'b1;
            res.kind  = efr_pkg::KIND_DATA;
            res.data  = sum_add;
            res.index = cnt_r;
            sum_nxt   = sum_r + sum_add;
            cnt_nxt   = cnt_p1;
            if (cnt_p1 >= len_r) phase_nxt = efr_pkg::PH_CKSUM;
          end
          efr_pkg::PH_CKSUM: begin
            sum_nxt   = sum_r + sum_add;
            res.valid = 1'b1;
            res.index = cnt_r;
            phase_nxt = efr_pkg::PH_HUNT;
            if (sum_r + sum_add != efr_pkg::SUM_GOOD) begin
              res.kind = efr_pkg::KIND_ERROR;
              res.err  = efr_pkg::ERR_CHECKSUM;
            end else begin
              res.kind = efr_pkg::KIND_GOOD;
            end
          end
          default: phase_nxt = efr_pkg::PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= efr_pkg::PH_HUNT;
      esc_r     <= 1'b0;
      len_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      max_len_r <= efr_pkg::MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      if (cfg_we) max_len_r <= cfg_data;
    end
  end

  a_err_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == efr_pkg::KIND_ERROR |-> res.err != efr_pkg::ERR_NONE)
    else $error("error result without error code");

  a_no_err_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind != efr_pkg::KIND_ERROR |-> res.err == efr_pkg::ERR_NONE)
    else $error("error code on non-error result");

  a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && (res.kind == efr_pkg::KIND_GOOD || res.kind == efr_pkg::KIND_ERROR)
    |=> phase_r == efr_pkg::PH_HUNT && !esc_r)
    else $error("frame end did not return to hunting");

  a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.kind == efr_pkg::KIND_DATA |=> cnt_r == $past(cnt_r) + 16'd1)
    else $error("payload count did not advance");

  a_result_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> fire)
    else $error("result without a transaction");

endmodule

### hdl/efr_out_reg.sv
module efr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  efr_pkg::result_t  res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic [15:0]       out_index,
  output logic [2:0]        out_error_code
);

  logic             valid_r, valid_nxt;
  efr_pkg::result_t data_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res.valid) data_r <= res;
  end

  assign out_valid      = valid_r;
  assign out_kind       = data_r.kind;
  assign out_byte       = data_r.data;
  assign out_index      = data_r.index;
  assign out_error_code = data_r.err;

endmodule

### hdl/escaped_api_frame_receiver_core.sv
// path: input register, decode, then a result (if any) in the register driving out_valid
// throughput: one byte per cycle; an input register feeds a single decode step that
// loads the result register, and the input side advances whenever that register can load
// reset: synchronous active-low rst_n; hunting for a start byte, no escape pending,
// counters and sum cleared, max_payload_len back to 256, both stages empty
module escaped_api_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_index,
  output logic [2:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload_len
);

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_byte_r;
  logic             out_free;
  logic             fire;
  efr_pkg::result_t res;

  // input stage drains into decode whenever the result register can load
  assign fire      = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) in_valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_rx_byte;
  end

  efr_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .rx_byte  (in_byte_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_max_payload_len),
    .res      (res)
  );

  efr_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_index      (out_index),
    .out_error_code (out_error_code)
  );

endmodule
